### rtl/rmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_pkg
// Shared constants, codes and types of the region material remapper.
// ----------------------------------------------------------------------------
package rmr_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ROT_STEPS_DEF   = 16;
  localparam int MAT_WIDTH_DEF   = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int BOUND_W    = 32;
  localparam int MVAL_W     = 17;
  localparam int MLIM_W     = 16;

  localparam int ANG_W   = 26;
  localparam int SQ_IN_W = 31;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 33;
  localparam int RAD_LAT = 3 + ROOT_W;

  // Angles are degrees in Q16.16, scaled from radians by 180/pi.
  localparam logic signed [ANG_W-1:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180_Q16 = 26'sd11796480;

  localparam logic signed [ANG_W-1:0] ATAN_DEG_Q16 [0:31] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0
  };

  typedef enum logic [2:0] {
    MODE_ALL     = 3'd0,
    MODE_XYZ     = 3'd1,
    MODE_CYL     = 3'd2,
    MODE_XYZ_ANY = 3'd3,
    MODE_CYL_ANY = 3'd4
  } region_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_MODE = 4'd0,
    REG_UPDATE_KIND = 4'd1,
    REG_MAT_VALUE   = 4'd2,
    REG_MAT_LOW     = 4'd3,
    REG_MAT_HIGH    = 4'd4,
    REG_AXIS1       = 4'd5,
    REG_AXIS2       = 4'd6,
    REG_AXIS3       = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]               region_mode;
    logic                     update_kind;
    logic signed [MVAL_W-1:0] mat_value;
    logic [MLIM_W-1:0]        mat_low;
    logic [MLIM_W-1:0]        mat_high;
    logic [2*BOUND_W-1:0]     axis1_bounds;
    logic [2*BOUND_W-1:0]     axis2_bounds;
    logic [2*BOUND_W-1:0]     axis3_bounds;
  } cfg_t;

endpackage

### rtl/rmr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_in_if
// Element channel: centroid and current material of one mesh element.
// ----------------------------------------------------------------------------
interface rmr_in_if #(
  parameter int COORD_WIDTH = rmr_pkg::COORD_WIDTH_DEF,
  parameter int MAT_WIDTH   = rmr_pkg::MAT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] cent_x;
  logic signed [COORD_WIDTH-1:0] cent_y;
  logic signed [COORD_WIDTH-1:0] cent_z;
  logic [MAT_WIDTH-1:0]          mat_in;

  modport source (output valid, output cent_x, output cent_y, output cent_z,
                  output mat_in, input ready);
  modport sink (input valid, input cent_x, input cent_y, input cent_z,
                input mat_in, output ready);
endinterface

### rtl/rmr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_out_if
// Result channel: new material and changed flag of one element.
// ----------------------------------------------------------------------------
interface rmr_out_if #(
  parameter int MAT_WIDTH = rmr_pkg::MAT_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [MAT_WIDTH-1:0] mat_out;
  logic                 changed;

  modport source (output valid, output mat_out, output changed, input ready);
  modport sink (input valid, input mat_out, input changed, output ready);
endinterface

### rtl/rmr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rmr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rmr_pkg::CFG_IDX_W-1:0]   index;
  logic [rmr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/rmr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module rmr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  rmr_cfg_if.sink       cfg_ch,
  output rmr_pkg::cfg_t cfg
);

  rmr_pkg::cfg_t cfg_r;
  rmr_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rmr_pkg::REG_REGION_MODE: cfg_nxt.region_mode  = cfg_ch.data[2:0];
        rmr_pkg::REG_UPDATE_KIND: cfg_nxt.update_kind  = cfg_ch.data[0];
        rmr_pkg::REG_MAT_VALUE:   cfg_nxt.mat_value    = $signed(cfg_ch.data[rmr_pkg::MVAL_W-1:0]);
        rmr_pkg::REG_MAT_LOW:     cfg_nxt.mat_low      = cfg_ch.data[rmr_pkg::MLIM_W-1:0];
        rmr_pkg::REG_MAT_HIGH:    cfg_nxt.mat_high     = cfg_ch.data[rmr_pkg::MLIM_W-1:0];
        rmr_pkg::REG_AXIS1:       cfg_nxt.axis1_bounds = cfg_ch.data;
        rmr_pkg::REG_AXIS2:       cfg_nxt.axis2_bounds = cfg_ch.data;
        rmr_pkg::REG_AXIS3:       cfg_nxt.axis3_bounds = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/rmr_radius.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_radius
// Pipelined radius: absolute values, squares, sum, then one root bit per stage.
// ----------------------------------------------------------------------------
module rmr_radius #(
  parameter int COORD_WIDTH = rmr_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  output logic [rmr_pkg::RAD_W-1:0]     rad
);

  localparam int AW    = (COORD_WIDTH > 32 ? COORD_WIDTH : 32) + 2;
  localparam int SQI   = rmr_pkg::SQ_IN_W;
  localparam int SQW   = rmr_pkg::SQ_W;
  localparam int RW    = rmr_pkg::ROOT_W;

  logic [COORD_WIDTH:0] xs, ys, xa, ya;
  logic [AW-1:0]        ax_full, ay_full;
  logic                 sat_nxt;

  logic [SQI-1:0]   ax_r, ay_r;
  logic             sat1_r, sat2_r;
  logic [2*SQI-1:0] sqx_r, sqy_r;
  logic [2*SQI-1:0] sqx_nxt, sqy_nxt;
  logic [SQW-1:0]   sum_nxt;

  logic [SQW-1:0] rem_r [0:RW];
  logic [RW-1:0]  q_r   [0:RW];
  logic           sat_r [0:RW];

  assign xs      = {x[COORD_WIDTH-1], x};
  assign ys      = {y[COORD_WIDTH-1], y};
  assign xa      = x[COORD_WIDTH-1] ? (~xs + 1'b1) : xs;
  assign ya      = y[COORD_WIDTH-1] ? (~ys + 1'b1) : ys;
  assign ax_full = {{(AW-COORD_WIDTH-1){1'b0}}, xa};
  assign ay_full = {{(AW-COORD_WIDTH-1){1'b0}}, ya};
  assign sat_nxt = (|ax_full[AW-1:SQI]) | (|ay_full[AW-1:SQI]);

  assign sqx_nxt = ax_r * ax_r;
  assign sqy_nxt = ay_r * ay_r;
  assign sum_nxt = {{(SQW-2*SQI){1'b0}}, sqx_r} + {{(SQW-2*SQI){1'b0}}, sqy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r     <= ax_full[SQI-1:0];
      ay_r     <= ay_full[SQI-1:0];
      sat1_r   <= sat_nxt;
      sqx_r    <= sqx_nxt;
      sqy_r    <= sqy_nxt;
      sat2_r   <= sat1_r;
      rem_r[0] <= sum_nxt;
      q_r[0]   <= '0;
      sat_r[0] <= sat2_r;
    end
  end

  for (genvar s = 0; s < RW; s++) begin : g_root
    localparam int J = RW - 1 - s;
    logic [SQW-1:0] trial;
    logic [SQW-1:0] rem_nxt;
    logic [RW-1:0]  q_nxt;

    assign trial = ({{(SQW-RW){1'b0}}, q_r[s]} << (J + 1)) | (SQW'(1) << (2 * J));

    always_comb begin
      if (rem_r[s] >= trial) begin
        rem_nxt = rem_r[s] - trial;
        q_nxt   = q_r[s] | (RW'(1) << J);
      end else begin
        rem_nxt = rem_r[s];
        q_nxt   = q_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_nxt;
        q_r[s+1]   <= q_nxt;
        sat_r[s+1] <= sat_r[s];
      end
    end
  end

  assign rad = sat_r[RW] ? (rmr_pkg::RAD_W'(1) << RW) : {1'b0, q_r[RW]};

endmodule

### rtl/rmr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_cordic
// Pipelined vectoring CORDIC giving the angle in Q16.16 degrees.
// ----------------------------------------------------------------------------
module rmr_cordic #(
  parameter int COORD_WIDTH = rmr_pkg::COORD_WIDTH_DEF,
  parameter int ROT_STEPS   = rmr_pkg::ROT_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_WIDTH-1:0]     x,
  input  logic signed [COORD_WIDTH-1:0]     y,
  output logic signed [rmr_pkg::ANG_W-1:0]  ang
);

  localparam int CW  = COORD_WIDTH + 3;
  localparam int ZW  = rmr_pkg::ANG_W;
  localparam int PAD = rmr_pkg::RAD_LAT - 2 - ROT_STEPS;

  logic signed [CW-1:0] xe, ye;
  logic signed [CW-1:0] x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;
  logic                 org_nxt;

  logic signed [CW-1:0] x_r   [0:ROT_STEPS];
  logic signed [CW-1:0] y_r   [0:ROT_STEPS];
  logic signed [ZW-1:0] z_r   [0:ROT_STEPS];
  logic                 org_r [0:ROT_STEPS];

  logic signed [ZW-1:0] ang_nxt;
  logic signed [ZW-1:0] ang_r;
  logic signed [ZW-1:0] pad_r [0:PAD-1];

  assign xe      = $signed({{3{x[COORD_WIDTH-1]}}, x});
  assign ye      = $signed({{3{y[COORD_WIDTH-1]}}, y});
  assign org_nxt = (x == '0) && (y == '0);

  // Points left of the y axis are first turned by a quarter turn.
  always_comb begin
    x0_nxt = xe;
    y0_nxt = ye;
    z0_nxt = '0;
    if (x[COORD_WIDTH-1]) begin
      if (!y[COORD_WIDTH-1]) begin
        x0_nxt = ye;
        y0_nxt = -xe;
        z0_nxt = rmr_pkg::DEG90_Q16;
      end else begin
        x0_nxt = -ye;
        y0_nxt = xe;
        z0_nxt = -rmr_pkg::DEG90_Q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= x0_nxt;
      y_r[0]   <= y0_nxt;
      z_r[0]   <= z0_nxt;
      org_r[0] <= org_nxt;
    end
  end

  for (genvar k = 0; k < ROT_STEPS; k++) begin : g_step
    logic signed [CW-1:0] dx, dy;
    logic signed [CW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;

    always_comb begin
      if (!y_r[k][CW-1]) begin
        x_nxt = x_r[k] + dx;
        y_nxt = y_r[k] - dy;
        z_nxt = z_r[k] + rmr_pkg::ATAN_DEG_Q16[k];
      end else begin
        x_nxt = x_r[k] - dx;
        y_nxt = y_r[k] + dy;
        z_nxt = z_r[k] - rmr_pkg::ATAN_DEG_Q16[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k+1]   <= x_nxt;
        y_r[k+1]   <= y_nxt;
        z_r[k+1]   <= z_nxt;
        org_r[k+1] <= org_r[k];
      end
    end
  end

  always_comb begin
    if (org_r[ROT_STEPS]) begin
      ang_nxt = '0;
    end else if (z_r[ROT_STEPS] > rmr_pkg::DEG180_Q16) begin
      ang_nxt = rmr_pkg::DEG180_Q16;
    end else if (z_r[ROT_STEPS] < -rmr_pkg::DEG180_Q16) begin
      ang_nxt = -rmr_pkg::DEG180_Q16;
    end else begin
      ang_nxt = z_r[ROT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r    <= ang_nxt;
      pad_r[0] <= ang_r;
    end
  end

  for (genvar p = 1; p < PAD; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        pad_r[p] <= pad_r[p-1];
      end
    end
  end

  assign ang = pad_r[PAD-1];

endmodule

### rtl/rmr_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmr_select
// Region and material tests, update with saturation, and result register.
// ----------------------------------------------------------------------------
module rmr_select #(
  parameter int COORD_WIDTH = rmr_pkg::COORD_WIDTH_DEF,
  parameter int MAT_WIDTH   = rmr_pkg::MAT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  rmr_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  input  logic signed [COORD_WIDTH-1:0]     x,
  input  logic signed [COORD_WIDTH-1:0]     y,
  input  logic signed [COORD_WIDTH-1:0]     z,
  input  logic [MAT_WIDTH-1:0]              mat,
  input  logic [rmr_pkg::RAD_W-1:0]         rad,
  input  logic signed [rmr_pkg::ANG_W-1:0]  ang,
  output logic                              res_valid,
  output logic [MAT_WIDTH-1:0]              res_mat,
  output logic                              res_changed
);

  localparam int PW  = (COORD_WIDTH > rmr_pkg::RAD_W ? COORD_WIDTH : rmr_pkg::RAD_W) + 1;
  localparam int MW  = (MAT_WIDTH > rmr_pkg::MLIM_W ? MAT_WIDTH : rmr_pkg::MLIM_W) + 1;
  localparam int SW  = (MAT_WIDTH > rmr_pkg::MVAL_W ? MAT_WIDTH : rmr_pkg::MVAL_W) + 2;
  localparam int BW  = rmr_pkg::BOUND_W;

  function automatic logic in_range(input logic signed [PW-1:0] p,
                                    input logic [2*BW-1:0] packed_b);
    logic signed [PW-1:0] lo;
    logic signed [PW-1:0] hi;
    lo = $signed({{(PW-BW){packed_b[BW-1]}}, packed_b[BW-1:0]});
    hi = $signed({{(PW-BW){packed_b[2*BW-1]}}, packed_b[2*BW-1:BW]});
    return (p >= lo) && (p <= hi);
  endfunction

  logic                 cyl;
  logic signed [PW-1:0] p1, p2, p3;
  logic [MW-1:0]        m_ext, lo_ext, hi_ext;
  logic signed [SW-1:0] v_ext, sum;
  logic [MAT_WIDTH-1:0] new_nxt;
  logic                 box_nxt, mok_nxt;

  logic                 v1_r, box_r, mok_r;
  logic [MAT_WIDTH-1:0] new_r, mat_r;
  logic                 sel;

  logic                 res_valid_r, res_changed_r;
  logic [MAT_WIDTH-1:0] res_mat_r;

  assign cyl = (cfg.region_mode == rmr_pkg::MODE_CYL) ||
               (cfg.region_mode == rmr_pkg::MODE_CYL_ANY);

  assign p1 = cyl ? $signed({{(PW-rmr_pkg::RAD_W){1'b0}}, rad})
                  : $signed({{(PW-COORD_WIDTH){x[COORD_WIDTH-1]}}, x});
  assign p2 = cyl ? $signed({{(PW-rmr_pkg::ANG_W){ang[rmr_pkg::ANG_W-1]}}, ang})
                  : $signed({{(PW-COORD_WIDTH){y[COORD_WIDTH-1]}}, y});
  assign p3 = $signed({{(PW-COORD_WIDTH){z[COORD_WIDTH-1]}}, z});

  assign box_nxt = in_range(p1, cfg.axis1_bounds) && in_range(p2, cfg.axis2_bounds) &&
                   in_range(p3, cfg.axis3_bounds);

  assign m_ext   = {{(MW-MAT_WIDTH){1'b0}}, mat};
  assign lo_ext  = {{(MW-rmr_pkg::MLIM_W){1'b0}}, cfg.mat_low};
  assign hi_ext  = {{(MW-rmr_pkg::MLIM_W){1'b0}}, cfg.mat_high};
  assign mok_nxt = (m_ext >= lo_ext) && (m_ext <= hi_ext);

  assign v_ext = $signed({{(SW-rmr_pkg::MVAL_W){cfg.mat_value[rmr_pkg::MVAL_W-1]}},
                          cfg.mat_value});
  assign sum   = cfg.update_kind ? ($signed({{(SW-MAT_WIDTH){1'b0}}, mat}) + v_ext) : v_ext;

  always_comb begin
    if (sum[SW-1]) begin
      new_nxt = '0;
    end else if (|sum[SW-1:MAT_WIDTH]) begin
      new_nxt = '1;
    end else begin
      new_nxt = sum[MAT_WIDTH-1:0];
    end
  end

  always_comb begin
    unique case (cfg.region_mode) inside
      rmr_pkg::MODE_ALL:                         sel = mok_r;
      rmr_pkg::MODE_XYZ, rmr_pkg::MODE_CYL:      sel = box_r && mok_r;
      rmr_pkg::MODE_XYZ_ANY, rmr_pkg::MODE_CYL_ANY: sel = box_r;
      default:                                   sel = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      res_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      box_r         <= box_nxt;
      mok_r         <= mok_nxt;
      new_r         <= new_nxt;
      mat_r         <= mat;
      res_mat_r     <= sel ? new_r : mat_r;
      res_changed_r <= sel;
    end
  end

  assign res_valid   = res_valid_r;
  assign res_mat     = res_mat_r;
  assign res_changed = res_changed_r;

endmodule

### rtl/region_material_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_material_remap
// Streams mesh elements, tests each against a region and material range,
// and rewrites the material of the selected ones.
// ----------------------------------------------------------------------------
// Elements arrive on in_ch (centroid x, y, z in signed Q16.16 and material)
// and results leave on out_ch (new material and changed flag), one result per
// element and in order. cfg_ch writes one register per transfer; it is always
// ready. Registers are to be written only while no element is in flight; the
// block itself does not enforce this. Throughput is one element per cycle
// while the skid register is empty. The path holds RAD_LAT + 2 = 37 register
// stages. The depth is set by the radius square root, which resolves one
// root bit per stage; the CORDIC runs ROT_STEPS stages beside it and is
// padded to the same depth.
// A synchronous reset clears all valid bits, the skid full flag and all
// configuration registers to zero.
// When the receiver stalls, the pending result moves into a one-entry skid
// register; in_ch stays ready in that cycle. While the skid register is full,
// the whole pipeline holds and in_ch.ready is low until the receiver takes
// the held result.
// ----------------------------------------------------------------------------
module region_material_remap #(
  parameter int COORD_WIDTH = rmr_pkg::COORD_WIDTH_DEF,
  parameter int ROT_STEPS   = rmr_pkg::ROT_STEPS_DEF,
  parameter int MAT_WIDTH   = rmr_pkg::MAT_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rmr_in_if.sink     in_ch,
  rmr_out_if.source  out_ch,
  rmr_cfg_if.sink    cfg_ch
);

  localparam int L = rmr_pkg::RAD_LAT;

  rmr_pkg::cfg_t cfg;

  logic en;
  logic accept;

  logic                          dv_r [0:L-1];
  logic signed [COORD_WIDTH-1:0] dx_r [0:L-1];
  logic signed [COORD_WIDTH-1:0] dy_r [0:L-1];
  logic signed [COORD_WIDTH-1:0] dz_r [0:L-1];
  logic [MAT_WIDTH-1:0]          dm_r [0:L-1];

  logic [rmr_pkg::RAD_W-1:0]        rad;
  logic signed [rmr_pkg::ANG_W-1:0] ang;

  logic                 res_valid;
  logic [MAT_WIDTH-1:0] res_mat;
  logic                 res_changed;

  logic                 sk_full_r, sk_full_nxt;
  logic [MAT_WIDTH-1:0] sk_mat_r;
  logic                 sk_chg_r;

  assign en          = !sk_full_r;
  assign in_ch.ready = en;
  assign accept      = in_ch.valid && en;

  rmr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rmr_radius #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_radius (
    .clk (clk),
    .en  (en),
    .x   (in_ch.cent_x),
    .y   (in_ch.cent_y),
    .rad (rad)
  );

  rmr_cordic #(
    .COORD_WIDTH (COORD_WIDTH),
    .ROT_STEPS   (ROT_STEPS)
  ) u_cordic (
    .clk (clk),
    .en  (en),
    .x   (in_ch.cent_x),
    .y   (in_ch.cent_y),
    .ang (ang)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= in_ch.cent_x;
      dy_r[0] <= in_ch.cent_y;
      dz_r[0] <= in_ch.cent_z;
      dm_r[0] <= in_ch.mat_in;
    end
  end

  for (genvar d = 1; d < L; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[d] <= 1'b0;
      end else if (en) begin
        dv_r[d] <= dv_r[d-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dx_r[d] <= dx_r[d-1];
        dy_r[d] <= dy_r[d-1];
        dz_r[d] <= dz_r[d-1];
        dm_r[d] <= dm_r[d-1];
      end
    end
  end

  rmr_select #(
    .COORD_WIDTH (COORD_WIDTH),
    .MAT_WIDTH   (MAT_WIDTH)
  ) u_select (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .cfg         (cfg),
    .in_valid    (dv_r[L-1]),
    .x           (dx_r[L-1]),
    .y           (dy_r[L-1]),
    .z           (dz_r[L-1]),
    .mat         (dm_r[L-1]),
    .rad         (rad),
    .ang         (ang),
    .res_valid   (res_valid),
    .res_mat     (res_mat),
    .res_changed (res_changed)
  );

  always_comb begin
    sk_full_nxt = sk_full_r;
    if (sk_full_r) begin
      if (out_ch.ready) begin
        sk_full_nxt = 1'b0;
      end
    end else if (res_valid && !out_ch.ready) begin
      sk_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_full_r <= 1'b0;
    end else begin
      sk_full_r <= sk_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_full_r) begin
      sk_mat_r <= res_mat;
      sk_chg_r <= res_changed;
    end
  end

  assign out_ch.valid   = sk_full_r || res_valid;
  assign out_ch.mat_out = sk_full_r ? sk_mat_r : res_mat;
  assign out_ch.changed = sk_full_r ? sk_chg_r : res_changed;

endmodule
